### design/histogram_bin_outlier_checker_macros.svh
`ifndef HISTOGRAM_BIN_OUTLIER_CHECKER_MACROS_SVH
`define HISTOGRAM_BIN_OUTLIER_CHECKER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HBO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle.
`define HBO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/hbo_pkg.sv
package hbo_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REL_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_ERR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CONST_REF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMITS     = 3'd7;

    // reset values
    localparam logic [31:0] ABS_LIMIT_RST = 32'hFFFF_0000;   // -1.0, disabled
    localparam logic [31:0] REL_LIMIT_RST = 32'hFFFF_0000;
    localparam logic [31:0] LIMITS_RST    = 32'h0014_0000;   // publish limit 20

    // mode bits
    localparam int MODE_USE_REF     = 0;
    localparam int MODE_IGN_REF0    = 1;
    localparam int MODE_IGN_IN0     = 2;
    localparam int MODE_GREATER     = 3;
    localparam int MODE_LESS        = 4;
    localparam int MODE_INC_REF_ERR = 5;
    localparam int MODE_PUBLISH     = 6;
    localparam int MODE_MIN_ENTRIES = 7;

    localparam logic [30:0] REL_ONE = 31'd65536;             // 1.0 in Q16.16

    typedef struct packed {
        logic [7:0]  mode;
        logic [15:0] sigma;
        logic [31:0] abs_lim;
        logic [31:0] rel_lim;
        logic [30:0] fixed_err;
        logic [31:0] const_ref;
        logic [31:0] thresh;
        logic [31:0] limits;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR_A,
        ST_ERR_B,
        ST_SIGMA,
        ST_DIFF,
        ST_RHS_LO,
        ST_RHS_HI,
        ST_REL,
        ST_DECIDE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ERR_A,
        MUL_ERR_B,
        MUL_SIGMA,
        MUL_DIFF,
        MUL_RHS_LO,
        MUL_RHS_HI,
        MUL_REL
    } t_mul_sel;

    typedef enum logic [1:0] {
        STAT_GREEN  = 2'd0,
        STAT_YELLOW = 2'd1,
        STAT_RED    = 2'd2
    } t_status;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        logic     decide;
    } t_dp_cmd;

endpackage

### design/hbo_regs.sv
module hbo_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [hbo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output hbo_pkg::t_cfg                  o_cfg
);
    import hbo_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:      n_cfg.mode      = i_cfg_data[7:0];
                REG_SIGMA:     n_cfg.sigma     = i_cfg_data[15:0];
                REG_ABS_LIMIT: n_cfg.abs_lim   = i_cfg_data;
                REG_REL_LIMIT: n_cfg.rel_lim   = i_cfg_data;
                REG_FIXED_ERR: n_cfg.fixed_err = i_cfg_data[30:0];
                REG_CONST_REF: n_cfg.const_ref = i_cfg_data;
                REG_THRESH:    n_cfg.thresh    = i_cfg_data;
                REG_LIMITS:    n_cfg.limits    = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= '0;
            r_cfg.sigma     <= '0;
            r_cfg.abs_lim   <= ABS_LIMIT_RST;
            r_cfg.rel_lim   <= REL_LIMIT_RST;
            r_cfg.fixed_err <= '0;
            r_cfg.const_ref <= '0;
            r_cfg.thresh    <= '0;
            r_cfg.limits    <= LIMITS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/hbo_ctrl.sv
`include "histogram_bin_outlier_checker_macros.svh"

module hbo_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hbo_pkg::t_dp_cmd o_cmd
);
    import hbo_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_block;

    // result register still holds an untaken word
    assign out_block = r_out_valid && !i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_ERR_A;
            ST_ERR_A:  n_state = ST_ERR_B;
            ST_ERR_B:  n_state = ST_SIGMA;
            ST_SIGMA:  n_state = ST_DIFF;
            ST_DIFF:   n_state = ST_RHS_LO;
            ST_RHS_LO: n_state = ST_RHS_HI;
            ST_RHS_HI: n_state = ST_REL;
            ST_REL:    n_state = ST_DECIDE;
            ST_DECIDE: if (!out_block) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.mul_sel  = MUL_NONE;
        o_cmd.decide   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_ERR_A:  o_cmd.mul_sel = MUL_ERR_A;
            ST_ERR_B:  o_cmd.mul_sel = MUL_ERR_B;
            ST_SIGMA:  o_cmd.mul_sel = MUL_SIGMA;
            ST_DIFF:   o_cmd.mul_sel = MUL_DIFF;
            ST_RHS_LO: o_cmd.mul_sel = MUL_RHS_LO;
            ST_RHS_HI: o_cmd.mul_sel = MUL_RHS_HI;
            ST_REL:    o_cmd.mul_sel = MUL_REL;
            ST_DECIDE: o_cmd.decide  = !out_block;
            default:   o_cmd.mul_sel = MUL_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.decide) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `HBO_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == ST_ERR_A, "accepted word did not start the sequence")
    `HBO_ASSERT_NEXT(a_decide_holds, i_clk, i_rst_n, r_state == ST_DECIDE && out_block, r_state == ST_DECIDE && r_out_valid, "result overwritten while stalled")
    `HBO_ASSERT_NEXT(a_decide_fills, i_clk, i_rst_n, o_cmd.decide, r_out_valid && r_state == ST_IDLE, "decided result not presented")

endmodule

### design/hbo_dp.sv
`include "histogram_bin_outlier_checker_macros.svh"

module hbo_dp #(
    parameter int COUNT_WIDTH = hbo_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hbo_pkg::t_dp_cmd i_cmd,
    input  hbo_pkg::t_cfg    i_cfg,
    input  logic [31:0]      i_bin_content,
    input  logic [30:0]      i_bin_error,
    input  logic [31:0]      i_ref_content,
    input  logic [30:0]      i_ref_error,
    input  logic [15:0]      i_bin_entries,
    input  logic             i_is_profile,
    input  logic             i_last_bin,
    output logic             o_outlier,
    output logic             o_publish_mark,
    output logic             o_skipped,
    output logic [15:0]      o_outlier_total,
    output logic [15:0]      o_skipped_total,
    output logic [1:0]       o_status,
    output logic             o_final_res
);
    import hbo_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // captured word
    logic [31:0] r_content;
    logic [30:0] r_herr;
    logic [31:0] r_rcont;
    logic [30:0] r_rerr;
    logic [15:0] r_entries;
    logic        r_profile;
    logic        r_last;

    // difference terms
    logic [31:0] r_x;
    logic [31:0] r_ar;
    logic        r_diff_neg;
    logic        r_diff_pos;
    logic        r_refv_zero;

    // products
    logic [63:0] r_qa;
    logic [63:0] r_qb;
    logic [62:0] r_q;
    logic [31:0] r_s2;
    logic [63:0] r_x2;
    logic [63:0] r_rhs_lo;
    logic [62:0] r_rhs_hi;
    logic [95:0] r_rhs;
    logic [62:0] r_relp;

    // counters and result
    logic [COUNT_WIDTH-1:0] r_flag_cnt;
    logic [COUNT_WIDTH-1:0] r_skip_cnt;
    logic [COUNT_WIDTH-1:0] n_flag_cnt;
    logic [COUNT_WIDTH-1:0] n_skip_cnt;
    logic        r_outlier;
    logic        r_pub;
    logic        r_skipped;
    logic [15:0] r_out_total;
    logic [15:0] r_skip_total;
    t_status     r_status;
    logic        r_final;

    logic        n_outlier;
    logic        n_pub;
    logic        n_skipped;
    t_status     n_status;

    logic [31:0] refv;
    logic [32:0] diff;
    logic [32:0] refv_abs;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic        incl_ref_err;

    logic        greater;
    logic        less;
    logic        check;
    logic        sig_ok;
    logic        abs_ok;
    logic        rel_ok;
    logic [CMP_W-1:0] cnt_cmp;
    logic [CMP_W-1:0] pub_lim;
    logic [CMP_W-1:0] green_th;
    logic [CMP_W-1:0] red_th;

    // reference and difference, worked out while the first product runs
    always_comb begin
        refv     = i_cfg.mode[MODE_USE_REF] ? r_rcont : i_cfg.const_ref;
        diff     = {r_content[31], r_content} - {refv[31], refv};
        refv_abs = refv[31] ? (33'd0 - {refv[31], refv}) : {1'b0, refv};
    end

    assign incl_ref_err = (i_cfg.fixed_err == '0) && i_cfg.mode[MODE_INC_REF_ERR]
                          && i_cfg.mode[MODE_USE_REF];

    // the one shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_ERR_A: begin
                mul_a = (i_cfg.fixed_err != '0) ? {1'b0, i_cfg.fixed_err} : {1'b0, r_herr};
                mul_b = mul_a;
            end
            MUL_ERR_B: begin
                mul_a = {1'b0, r_rerr};
                mul_b = {1'b0, r_rerr};
            end
            MUL_SIGMA: begin
                mul_a = {16'd0, i_cfg.sigma};
                mul_b = {16'd0, i_cfg.sigma};
            end
            MUL_DIFF: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            MUL_RHS_LO: begin
                mul_a = r_s2;
                mul_b = r_q[31:0];
            end
            MUL_RHS_HI: begin
                mul_a = r_s2;
                mul_b = {1'b0, r_q[62:32]};
            end
            MUL_REL: begin
                mul_a = {1'b0, i_cfg.rel_lim[30:0]};
                mul_b = r_ar;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_content <= i_bin_content;
            r_herr    <= i_bin_error;
            r_rcont   <= i_ref_content;
            r_rerr    <= i_ref_error;
            r_entries <= i_bin_entries;
            r_profile <= i_is_profile;
            r_last    <= i_last_bin;
        end
        case (i_cmd.mul_sel)
            MUL_ERR_A: begin
                r_qa        <= mul_p;
                r_x         <= diff[32] ? 32'(33'd0 - diff) : diff[31:0];
                r_ar        <= refv_abs[31:0];
                r_diff_neg  <= diff[32];
                r_diff_pos  <= !diff[32] && (diff != '0);
                r_refv_zero <= (refv == '0);
            end
            MUL_ERR_B: r_qb <= mul_p;
            MUL_SIGMA: begin
                r_s2 <= mul_p[31:0];
                r_q  <= 63'(r_qa + (incl_ref_err ? r_qb : 64'd0));
            end
            MUL_DIFF:   r_x2     <= mul_p;
            MUL_RHS_LO: r_rhs_lo <= mul_p;
            MUL_RHS_HI: r_rhs_hi <= mul_p[62:0];
            MUL_REL: begin
                r_relp <= mul_p[62:0];
                r_rhs  <= {1'b0, r_rhs_hi, 32'd0} + {32'd0, r_rhs_lo};
            end
            default: r_x2 <= r_x2;
        endcase
    end

    // decision on the finished products
    always_comb begin
        greater = i_cfg.mode[MODE_GREATER] && !i_cfg.mode[MODE_LESS];
        less    = i_cfg.mode[MODE_LESS] && !i_cfg.mode[MODE_GREATER];

        n_skipped = i_cfg.mode[MODE_MIN_ENTRIES] && r_profile
                    && (r_entries < i_cfg.limits[15:0]);

        check = !n_skipped;
        if (i_cfg.mode[MODE_IGN_REF0] && r_refv_zero) check = 1'b0;
        if (i_cfg.mode[MODE_IGN_REF0] && !i_cfg.mode[MODE_USE_REF] && (r_content == '0)) begin
            check = 1'b0;
        end
        if (i_cfg.mode[MODE_IGN_IN0] && (r_content == '0)) check = 1'b0;
        if (r_q == '0) check = 1'b0;
        if (greater && r_diff_neg) check = 1'b0;
        if (less && r_diff_pos) check = 1'b0;

        sig_ok = {16'd0, r_x2, 16'd0} > r_rhs;
        abs_ok = i_cfg.abs_lim[31] || ({1'b0, r_x} > {2'b00, i_cfg.abs_lim[30:0]});
        if (i_cfg.rel_lim[31]) begin
            rel_ok = 1'b1;
        end else if (!r_refv_zero) begin
            rel_ok = {15'd0, r_x, 16'd0} > r_relp;
        end else begin
            rel_ok = (r_x != '0) && (i_cfg.rel_lim[30:0] < REL_ONE);
        end

        n_outlier  = check && sig_ok && abs_ok && rel_ok;
        n_flag_cnt = (n_outlier && (r_flag_cnt != CNT_MAX)) ?
                     r_flag_cnt + COUNT_WIDTH'(1) : r_flag_cnt;
        n_skip_cnt = (n_skipped && (r_skip_cnt != CNT_MAX)) ?
                     r_skip_cnt + COUNT_WIDTH'(1) : r_skip_cnt;

        cnt_cmp  = CMP_W'(n_flag_cnt);
        pub_lim  = CMP_W'(i_cfg.limits[31:16]);
        green_th = CMP_W'(i_cfg.thresh[15:0]);
        red_th   = CMP_W'(i_cfg.thresh[31:16]);

        n_pub = n_outlier && i_cfg.mode[MODE_PUBLISH] && (cnt_cmp < pub_lim);

        n_status = STAT_GREEN;
        if (r_last) begin
            if (green_th > red_th) begin
                if (cnt_cmp >= green_th)   n_status = STAT_GREEN;
                else if (cnt_cmp > red_th) n_status = STAT_YELLOW;
                else                       n_status = STAT_RED;
            end else begin
                if (cnt_cmp <= green_th)   n_status = STAT_GREEN;
                else if (cnt_cmp < red_th) n_status = STAT_YELLOW;
                else                       n_status = STAT_RED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_cnt <= '0;
            r_skip_cnt <= '0;
            r_outlier  <= 1'b0;
            r_pub      <= 1'b0;
            r_skipped  <= 1'b0;
            r_status   <= STAT_GREEN;
            r_final    <= 1'b0;
        end else if (i_cmd.decide) begin
            r_flag_cnt <= r_last ? '0 : n_flag_cnt;
            r_skip_cnt <= r_last ? '0 : n_skip_cnt;
            r_outlier  <= n_outlier;
            r_pub      <= n_pub;
            r_skipped  <= n_skipped;
            r_status   <= n_status;
            r_final    <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_out_total  <= 16'(n_flag_cnt);
            r_skip_total <= 16'(n_skip_cnt);
        end
    end

    assign o_outlier       = r_outlier;
    assign o_publish_mark  = r_pub;
    assign o_skipped       = r_skipped;
    assign o_outlier_total = r_out_total;
    assign o_skipped_total = r_skip_total;
    assign o_status        = r_status;
    assign o_final_res     = r_final;

    `HBO_ASSERT_NOW(a_skip_excl, i_clk, i_rst_n, r_skipped, !r_outlier && !r_pub, "skipped bin carries a flag")
    `HBO_ASSERT_NOW(a_pub_flag, i_clk, i_rst_n, r_pub, r_outlier, "publish mark without flag")
    `HBO_ASSERT_NOW(a_status_final, i_clk, i_rst_n, !r_final, r_status == STAT_GREEN, "status set on a bin that is not last")

endmodule

### design/histogram_bin_outlier_checker.sv
// Histogram bin outlier checker.
// Bins stream in on the input channel (i_in_valid / o_in_ready), one bin per
// word with content, error, reference content and error, entries and flags.
// One result word per bin leaves on the output channel (o_out_valid /
// i_out_ready): flag, publish mark, skip flag, running totals, and on the
// last bin the green/yellow/red status with o_final_res set.
// Configuration: i_cfg_valid with index and data; o_cfg_ready is always high.
// Write only while the checker is idle.
// One bin at a time: a new bin is taken only once the last one has left
// the sequence, set by the single shared 32x32 multiplier that
// forms seven products in turn (error squares, sigma square, difference
// square, the split sigma-times-error product, relative limit product),
// then the compares.
// A finished result sits in the output register; a new bin is taken while it
// waits, and the decision step holds until that register is free.
// Reset (synchronous, active low) loads register defaults and clears both
// counters; counters also clear after every last bin.
module histogram_bin_outlier_checker #(
    parameter int COUNT_WIDTH = hbo_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hbo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // bin words in
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [31:0]                    i_bin_content,
    input  logic [30:0]                    i_bin_error,
    input  logic [31:0]                    i_ref_content,
    input  logic [30:0]                    i_ref_error,
    input  logic [15:0]                    i_bin_entries,
    input  logic                           i_is_profile,
    input  logic                           i_last_bin,
    // result words out
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_outlier,
    output logic                           o_publish_mark,
    output logic                           o_skipped,
    output logic [15:0]                    o_outlier_total,
    output logic [15:0]                    o_skipped_total,
    output logic [1:0]                     o_status,
    output logic                           o_final_res
);
    import hbo_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;

    // registers take a write every cycle
    assign o_cfg_ready = 1'b1;

    hbo_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer: steps the shared multiplier and owns the result handshake
    hbo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // arithmetic, counters and result register
    hbo_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (cfg),
        .i_bin_content   (i_bin_content),
        .i_bin_error     (i_bin_error),
        .i_ref_content   (i_ref_content),
        .i_ref_error     (i_ref_error),
        .i_bin_entries   (i_bin_entries),
        .i_is_profile    (i_is_profile),
        .i_last_bin      (i_last_bin),
        .o_outlier       (o_outlier),
        .o_publish_mark  (o_publish_mark),
        .o_skipped       (o_skipped),
        .o_outlier_total (o_outlier_total),
        .o_skipped_total (o_skipped_total),
        .o_status        (o_status),
        .o_final_res     (o_final_res)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import hbo_pkg::*;

    localparam logic [31:0] ONE         = 32'h0001_0000;   // 1.0 in Q16.16
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;        // counters saturate here
    localparam int          STALL_LIMIT = 5000;            // cycles with no word moved
    localparam int          PRINT_LIMIT = 200;

    // One bin word as it goes into the checker
    typedef struct packed {
        logic [31:0] content;
        logic [30:0] bin_err;
        logic [31:0] ref_cont;
        logic [30:0] ref_err;
        logic [15:0] entries;
        logic        profile;
        logic        last;
    } t_bin;

    // One result word as the checker should return it
    typedef struct packed {
        logic        outlier;
        logic        publish;
        logic        skipped;
        logic [15:0] outlier_total;
        logic [15:0] skip_total;
        logic [1:0]  status;
        logic        final_res;
    } t_verdict;

    typedef enum {CFG_TYPICAL, CFG_EXTREME, CFG_WILD} t_cfg_style;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Configuration channel
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Bin words in
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [31:0] bin_content = '0;
    logic [30:0] bin_error   = '0;
    logic [31:0] ref_content = '0;
    logic [30:0] ref_error   = '0;
    logic [15:0] bin_entries = '0;
    logic        is_profile  = 1'b0;
    logic        last_bin    = 1'b0;

    // Result words out
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        outlier;
    logic        publish_mark;
    logic        skipped;
    logic [15:0] outlier_total;
    logic [15:0] skipped_total;
    logic [1:0]  status;
    logic        final_res;

    histogram_bin_outlier_checker u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_bin_content   (bin_content),
        .i_bin_error     (bin_error),
        .i_ref_content   (ref_content),
        .i_ref_error     (ref_error),
        .i_bin_entries   (bin_entries),
        .i_is_profile    (is_profile),
        .i_last_bin      (last_bin),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_outlier       (outlier),
        .o_publish_mark  (publish_mark),
        .o_skipped       (skipped),
        .o_outlier_total (outlier_total),
        .o_skipped_total (skipped_total),
        .o_status        (status),
        .o_final_res     (final_res)
    );

    // Shadow of the checker's registers and counters, kept in step with
    // every accepted config word and bin word.
    t_cfg        cfg;
    logic [15:0] flag_tally = '0;
    logic [15:0] skip_tally = '0;

    // Results predicted for accepted bins, oldest first
    t_verdict pending_verdicts[$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  stall_cycles = 0;
    int  hold_req     = 0;       // long receiver hold, taken up by the sink
    bit  in_idle      = 1'b0;    // sender inserts random gaps
    bit  out_idle     = 1'b0;    // receiver inserts random stalls

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic t_cfg reset_cfg();
        t_cfg c;
        c.mode      = '0;
        c.sigma     = '0;
        c.abs_lim   = ABS_LIMIT_RST;
        c.rel_lim   = REL_LIMIT_RST;
        c.fixed_err = '0;
        c.const_ref = '0;
        c.thresh    = '0;
        c.limits    = LIMITS_RST;
        return c;
    endfunction

    // Works out the result word of one bin and advances the counters.
    // The sigma test is diff^2 * 2^16 > sigma^2 * err^2, done exactly in
    // 128 bits; the relative test is |diff| * 2^16 > rel * |ref|.
    function automatic t_verdict judge_bin(input t_bin b);
        t_verdict     v;
        longint       content, refv, diff, mag, rel, span;
        logic [63:0]  err_sq, be, re, fe;
        logic [127:0] lhs, rhs, w;
        logic         use_ref, up_only, down_only, live, sig_ok, abs_ok, rel_ok;
        logic [15:0]  green, red;
        v = '0;
        v.status = STAT_GREEN;
        use_ref = cfg.mode[MODE_USE_REF];
        if (cfg.mode[MODE_MIN_ENTRIES] && b.profile && b.entries < cfg.limits[15:0]) begin
            v.skipped = 1'b1;
            if (skip_tally != COUNT_MAX)
                skip_tally++;
        end else begin
            content = longint'($signed(b.content));
            refv = use_ref ? longint'($signed(b.ref_cont)) : longint'($signed(cfg.const_ref));
            diff = content - refv;
            mag = (diff < 0) ? -diff : diff;
            // greater and less together mean no direction rule
            up_only = cfg.mode[MODE_GREATER] && !cfg.mode[MODE_LESS];
            down_only = cfg.mode[MODE_LESS] && !cfg.mode[MODE_GREATER];
            be = 64'(b.bin_err);
            re = 64'(b.ref_err);
            if (cfg.fixed_err != '0) begin
                fe = 64'(cfg.fixed_err);
                err_sq = fe * fe;
            end else if (cfg.mode[MODE_INC_REF_ERR] && use_ref) begin
                err_sq = be * be + re * re;
            end else begin
                err_sq = be * be;
            end
            live = 1'b1;
            if (cfg.mode[MODE_IGN_REF0] && refv == 0)
                live = 1'b0;
            if (cfg.mode[MODE_IGN_REF0] && !use_ref && content == 0)
                live = 1'b0;
            if (cfg.mode[MODE_IGN_IN0] && content == 0)
                live = 1'b0;
            if (err_sq == 0)
                live = 1'b0;
            if (up_only && diff < 0)
                live = 1'b0;
            if (down_only && diff > 0)
                live = 1'b0;
            if (live) begin
                w = 128'(mag);
                lhs = (w * w) << 16;
                w = 128'(cfg.sigma);
                rhs = w * w * 128'(err_sq);
                sig_ok = lhs > rhs;
                abs_ok = mag > longint'($signed(cfg.abs_lim));
                rel = longint'($signed(cfg.rel_lim));
                if (rel < 0) begin
                    rel_ok = 1'b1;
                end else if (refv != 0) begin
                    span = (refv < 0) ? -refv : refv;
                    rel_ok = (mag <<< 16) > rel * span;
                end else begin
                    // zero reference: relative deviation counts as 1.0
                    rel_ok = (mag != 0) && (rel < 65536);
                end
                if (sig_ok && abs_ok && rel_ok) begin
                    v.outlier = 1'b1;
                    if (flag_tally != COUNT_MAX)
                        flag_tally++;
                    v.publish = cfg.mode[MODE_PUBLISH] && (flag_tally < cfg.limits[31:16]);
                end
            end
        end
        v.outlier_total = flag_tally;
        v.skip_total = skip_tally;
        if (b.last) begin
            green = cfg.thresh[15:0];
            red = cfg.thresh[31:16];
            if (green > red)
                v.status = (flag_tally >= green) ? STAT_GREEN :
                           (flag_tally > red) ? STAT_YELLOW : STAT_RED;
            else
                v.status = (flag_tally <= green) ? STAT_GREEN :
                           (flag_tally < red) ? STAT_YELLOW : STAT_RED;
            v.final_res = 1'b1;
            flag_tally = '0;
            skip_tally = '0;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [31:0] q16(input int v);
        return v <<< 16;
    endfunction

    function automatic t_bin mk_bin(input logic [31:0] content, input logic [30:0] bin_err,
                                    input logic [31:0] ref_cont, input logic [30:0] ref_err,
                                    input logic [15:0] entries, input logic profile,
                                    input logic last);
        t_bin b;
        b.content  = content;
        b.bin_err  = bin_err;
        b.ref_cont = ref_cont;
        b.ref_err  = ref_err;
        b.entries  = entries;
        b.profile  = profile;
        b.last     = last;
        return b;
    endfunction

    function automatic logic [30:0] rand_err();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h0002_0000));
        endcase
    endfunction

    // Bins mostly sit a few units around the comparison value so that the
    // sigma, absolute and relative tests all go both ways.
    function automatic t_bin rand_bin();
        t_bin        b;
        logic [31:0] centre;
        case ($urandom_range(0, 9))
            0: b.ref_cont = '0;
            1: b.ref_cont = $urandom;
            default: b.ref_cont = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
        centre = cfg.mode[MODE_USE_REF] ? b.ref_cont : cfg.const_ref;
        case ($urandom_range(0, 9))
            0: b.content = '0;
            1: b.content = $urandom;
            2: b.content = centre;
            default: b.content = centre + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
        b.bin_err = rand_err();
        b.ref_err = rand_err();
        b.entries = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        b.profile = 1'($urandom_range(0, 1));
        b.last = ($urandom_range(0, 15) == 0);
        return b;
    endfunction

    function automatic t_cfg rand_cfg(input t_cfg_style style);
        t_cfg c;
        case (style)
            CFG_EXTREME: begin
                c.mode      = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                c.sigma     = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                c.abs_lim   = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                c.rel_lim   = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                c.fixed_err = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
                c.const_ref = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                c.thresh    = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                c.limits    = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            end
            CFG_WILD: begin
                c.mode      = 8'($urandom);
                c.sigma     = 16'($urandom);
                c.abs_lim   = $urandom;
                c.rel_lim   = $urandom;
                c.fixed_err = 31'($urandom);
                c.const_ref = $urandom;
                c.thresh    = $urandom;
                c.limits    = $urandom;
            end
            default: begin
                c.mode      = 8'($urandom);
                c.sigma     = 16'($urandom_range(0, 16'h0500));
                c.abs_lim   = ($urandom_range(0, 3) == 0) ? ABS_LIMIT_RST :
                              $urandom_range(0, 32'h0004_0000);
                c.rel_lim   = ($urandom_range(0, 3) == 0) ? REL_LIMIT_RST :
                              $urandom_range(0, 32'h0001_8000);
                c.fixed_err = ($urandom_range(0, 3) == 0) ?
                              31'($urandom_range(1, 32'h0004_0000)) : 31'h0;
                c.const_ref = ($urandom_range(0, 2) == 0) ? 32'h0 :
                              $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                c.thresh    = {16'($urandom_range(0, 12)), 16'($urandom_range(0, 12))};
                c.limits    = {16'($urandom_range(0, 15)), 16'($urandom_range(0, 30))};
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------

    // Drops valid and waits for every predicted result word to come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Valid is left high on return so back-to-back words need no second
    // assignment in the same step; the caller lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MODE:      cfg.mode      = data[7:0];
            REG_SIGMA:     cfg.sigma     = data[15:0];
            REG_ABS_LIMIT: cfg.abs_lim   = data;
            REG_REL_LIMIT: cfg.rel_lim   = data;
            REG_FIXED_ERR: cfg.fixed_err = data[30:0];
            REG_CONST_REF: cfg.const_ref = data;
            REG_THRESH:    cfg.thresh    = data;
            REG_LIMITS:    cfg.limits    = data;
            default: ;
        endcase
    endtask

    // Registers only change once the checker has gone quiet
    task automatic set_config(input t_cfg c);
        drain_results();
        write_reg(REG_MODE,      32'(c.mode));
        write_reg(REG_SIGMA,     32'(c.sigma));
        write_reg(REG_ABS_LIMIT, c.abs_lim);
        write_reg(REG_REL_LIMIT, c.rel_lim);
        write_reg(REG_FIXED_ERR, 32'(c.fixed_err));
        write_reg(REG_CONST_REF, c.const_ref);
        write_reg(REG_THRESH,    c.thresh);
        write_reg(REG_LIMITS,    c.limits);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_bin(input t_bin b);
        int gap;
        if (in_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        bin_content <= b.content;
        bin_error   <= b.bin_err;
        ref_content <= b.ref_cont;
        ref_error   <= b.ref_err;
        bin_entries <= b.entries;
        is_profile  <= b.profile;
        last_bin    <= b.last;
        do @(posedge clk); while (!in_ready);
        pending_verdicts.push_back(judge_bin(b));
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_bin(rand_bin());
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                    results_seen, name, got, want));
    endtask

    always @(posedge clk) begin : result_check
        t_verdict want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                note_mismatch($sformatf("result %0d arrived with no bin pending", results_seen));
            end else begin
                want = pending_verdicts.pop_front();
                check_field("outlier",       32'(outlier),       32'(want.outlier));
                check_field("publish_mark",  32'(publish_mark),  32'(want.publish));
                check_field("skipped",       32'(skipped),       32'(want.skipped));
                check_field("outlier_total", 32'(outlier_total), 32'(want.outlier_total));
                check_field("skipped_total", 32'(skipped_total), 32'(want.skip_total));
                check_field("status",        32'(status),        32'(want.status));
                check_field("final_res",     32'(final_res),     32'(want.final_res));
            end
        end
    end

    // Receiver: ready in random runs, random stalls when enabled, and a
    // long hold whenever a test asks for one.
    initial begin : result_sink
        int span;
        @(posedge clk);
        forever begin
            if (hold_req != 0) begin
                out_ready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end else if (out_idle && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                span = $urandom_range(1, 19);
                repeat (span) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                span = $urandom_range(1, 19);
                repeat (span) @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == STALL_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
            $display("histogram_bin_outlier_checker: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults straight after reset: constant reference of zero,
    // sigma zero, both limits off.
    task automatic test_reset_defaults();
        t_bin b;
        send_random(4);
        b = rand_bin();
        b.last = 1'b1;
        send_bin(b);
    endtask

    task automatic test_directed_cases();
        t_cfg c;
        // reference histogram, quadrature errors, entry check, publish limit 2
        c = reset_cfg();
        c.mode = '0;
        c.mode[MODE_USE_REF]     = 1'b1;
        c.mode[MODE_IGN_REF0]    = 1'b1;
        c.mode[MODE_INC_REF_ERR] = 1'b1;
        c.mode[MODE_PUBLISH]     = 1'b1;
        c.mode[MODE_MIN_ENTRIES] = 1'b1;
        c.sigma   = 16'h0300;                       // 3 sigma
        c.abs_lim = 32'h0;
        c.rel_lim = 32'h0000_199A;                  // 0.1
        c.thresh  = {16'd3, 16'd1};
        c.limits  = {16'd2, 16'd10};
        set_config(c);
        send_bin(mk_bin(q16(10), ONE[30:0], q16(5), ONE[30:0], 16'd5, 1'b1, 1'b0));   // too few
        send_bin(mk_bin(q16(10), ONE[30:0], q16(5), ONE[30:0], 16'd10, 1'b1, 1'b0));  // at minimum
        send_bin(mk_bin(q16(10), ONE[30:0], 32'h0, ONE[30:0], 16'd0, 1'b0, 1'b0));    // zero ref
        send_bin(mk_bin(q16(3), 31'h0, q16(4), 31'h0, 16'd0, 1'b0, 1'b0));            // no error
        send_bin(mk_bin(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                        16'hFFFF, 1'b1, 1'b0));
        send_bin(mk_bin(32'h8000_0000, ONE[30:0], 32'h7FFF_FFFF, 31'h0, 16'hFFFF, 1'b0, 1'b0));
        send_bin(mk_bin(q16(-9), ONE[30:0], q16(2), 31'h0, 16'd0, 1'b0, 1'b1));

        // both directions set, zero input ignored, every limit at its top
        c = reset_cfg();
        c.mode = '0;
        c.mode[MODE_GREATER] = 1'b1;
        c.mode[MODE_LESS]    = 1'b1;
        c.mode[MODE_IGN_IN0] = 1'b1;
        c.sigma     = 16'hFFFF;
        c.abs_lim   = 32'h7FFF_FFFF;
        c.rel_lim   = 32'h7FFF_FFFF;
        c.fixed_err = 31'h7FFF_FFFF;
        c.const_ref = 32'h8000_0000;
        c.thresh    = {16'd2, 16'd5};               // green above red
        c.limits    = 32'hFFFF_FFFF;
        set_config(c);
        send_bin(mk_bin(32'h0, 31'h0, 32'h0, 31'h0, 16'd0, 1'b1, 1'b0));
        send_bin(mk_bin(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0, 31'h0, 16'd0, 1'b0, 1'b1));

        // greater only against a zero constant: relative deviation taken as 1.0
        c = reset_cfg();
        c.mode = '0;
        c.mode[MODE_GREATER] = 1'b1;
        c.abs_lim = 32'h0;
        c.rel_lim = 32'h0000_FFFF;
        c.thresh  = 32'h0;
        set_config(c);
        send_bin(mk_bin(q16(2), ONE[30:0], 32'h0, 31'h0, 16'd0, 1'b0, 1'b0));
        send_bin(mk_bin(q16(-2), ONE[30:0], 32'h0, 31'h0, 16'd0, 1'b0, 1'b0));
        send_bin(mk_bin(32'h0, ONE[30:0], 32'h0, 31'h0, 16'd0, 1'b0, 1'b1));

        // less only, zero input ignored through the zero-reference rule
        c.mode = '0;
        c.mode[MODE_LESS]     = 1'b1;
        c.mode[MODE_IGN_REF0] = 1'b1;
        c.rel_lim   = ONE;
        c.const_ref = ONE;
        c.thresh    = {16'd1, 16'd1};
        set_config(c);
        send_bin(mk_bin(32'h0, ONE[30:0], 32'h0, 31'h0, 16'd0, 1'b0, 1'b0));
        send_bin(mk_bin(q16(-3), ONE[30:0], 32'h0, 31'h0, 16'd0, 1'b0, 1'b0));
        send_bin(mk_bin(q16(3), ONE[30:0], 32'h0, 31'h0, 16'd0, 1'b0, 1'b1));
    endtask

    // Phases of random bins, each under a fresh register setting; idling
    // switched on and off per phase.
    task automatic test_random_phases();
        t_cfg_style style;
        for (int p = 0; p < 11; p++) begin
            style = (p % 3 == 1) ? CFG_EXTREME : (p % 3 == 2) ? CFG_WILD : CFG_TYPICAL;
            set_config(rand_cfg(style));
            in_idle  = (p % 4 != 3);
            out_idle = (p % 4 != 2);
            send_random(140);
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the checker
    // fills and stalls its input; then the sender waits for every result.
    task automatic test_backpressure();
        set_config(rand_cfg(CFG_TYPICAL));
        in_idle  = 1'b0;
        out_idle = 1'b0;
        hold_req = 300;
        send_random(40);
        drain_results();
        in_idle  = 1'b1;
        out_idle = 1'b1;
        send_random(20);
    endtask

    // Every bin flagged; the publish mark drops once the flagged count
    // reaches the publish limit.
    task automatic test_publish_limit();
        t_cfg c;
        c = reset_cfg();
        c.mode = '0;
        c.mode[MODE_PUBLISH] = 1'b1;
        c.fixed_err = ONE[30:0];
        c.limits    = {16'd12, 16'd0};
        set_config(c);
        in_idle  = 1'b0;
        out_idle = 1'b0;
        repeat (20)
            send_bin(mk_bin(ONE, 31'h0, 32'h0, 31'h0, 16'd0, 1'b0, 1'b0));
        send_bin(mk_bin(ONE, 31'h0, 32'h0, 31'h0, 16'd0, 1'b0, 1'b1));
    endtask

    // Closing stretch at full rate, no idling on either side
    task automatic test_steady_stream();
        set_config(rand_cfg(CFG_TYPICAL));
        in_idle  = 1'b0;
        out_idle = 1'b0;
        send_random(250);
    endtask

    initial begin
        cfg = reset_cfg();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_random_phases();
        test_backpressure();
        test_publish_limit();
        test_steady_stream();
        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("histogram_bin_outlier_checker: match");
        else
            $display("histogram_bin_outlier_checker: mismatch");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/hbo_pkg.sv
design/hbo_regs.sv
design/hbo_ctrl.sv
design/hbo_dp.sv
design/histogram_bin_outlier_checker.sv
tb/tb.sv
